FILE: design/tbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types and constants of the timer bank scheduler.
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int TIME_W      = 32;
    localparam int IVL_W       = 31;
    localparam int ID_W        = 4;
    localparam int MAX_RESULTS = 16;
    localparam int REP_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_DELETE = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CREATED = 3'd0,
        ST_DELETED = 3'd1,
        ST_FIRED   = 3'd2,
        ST_NONE    = 3'd3,
        ST_FAILED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_TICK,
        S_FINISH,
        S_SINGLE
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic              last;
    } rsp_beat_t;

endpackage
`default_nettype wire

FILE: design/tbs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_if
// Command and response channels of the timer bank scheduler.
// ----------------------------------------------------------------------------
interface tbs_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [30:0] interval;
    logic        repeat_mode;
    logic [3:0]  timer_id;

    modport source (output valid, output operation, output interval,
                    output repeat_mode, output timer_id, input ready);
    modport sink   (input valid, input operation, input interval,
                    input repeat_mode, input timer_id, output ready);
endinterface

interface tbs_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] result_id;
    logic       last;

    modport source (output valid, output status, output result_id,
                    output last, input ready);
    modport sink   (input valid, input status, input result_id,
                    input last, output ready);
endinterface
`default_nettype wire

FILE: design/timer_bank_scheduler_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Create checks one slot per cycle until it finds a free one, where it waits
//   for the response register; tick reads one slot from the timer RAM per
//   cycle, holding when a fired beat finds the response register full.
// Throughput: one command at a time; the next is taken once the last beat
//   of the current one is in the response register.
// Reset clears the used and periodic flags and the time counter, not the RAM.
// ----------------------------------------------------------------------------
// timer_bank_scheduler_core
// Bank of one-shot and periodic timers driven by a tick counter.
// ----------------------------------------------------------------------------
module timer_bank_scheduler_core #(
    parameter int NUM_TIMERS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tbs_cmd_if.sink   cmd,
    tbs_rsp_if.source rsp
);
    import tbs_pkg::*;

    localparam int IDW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW  = $clog2(NUM_TIMERS + 1);
    localparam int SW  = IVL_W + TIME_W;
    localparam logic [CW-1:0]    LAST_CNT = CW'(NUM_TIMERS);
    localparam logic [REP_W-1:0] REP_MAX  = REP_W'(MAX_RESULTS);

    state_t                  state_reg, state_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic [NUM_TIMERS-1:0]   used_reg, used_next;
    logic [NUM_TIMERS-1:0]   per_reg, per_next;
    logic [1:0]              op_reg, op_next;
    logic [IVL_W-1:0]        ivl_reg, ivl_next;
    logic                    rep_mode_reg, rep_mode_next;
    logic [ID_W-1:0]         tid_reg, tid_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    ev_valid_reg, ev_valid_next;
    logic [IDW-1:0]          ev_idx_reg, ev_idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]         pend_id_reg, pend_id_next;
    logic [REP_W-1:0]        rep_cnt_reg, rep_cnt_next;

    logic                    cmd_acc;
    logic [IDW-1:0]          cnt_idx;
    logic [IDW+ID_W-1:0]     cnt_id_ext, ev_id_ext;
    logic [ID_W-1:0]         cnt_id, ev_id;
    logic                    scan_end, slot_free;
    logic [NUM_TIMERS-1:0]   tid_hot;
    logic                    del_hit;
    logic [SW-1:0]           ram_rdata, ram_wdata;
    logic [IVL_W-1:0]        rd_ivl, ivl_sel;
    logic [TIME_W-1:0]       rd_dl, diff, new_dl;
    logic                    due, ev_fire, ev_rep, tick_stall;
    logic                    ram_we, ram_re;
    logic [IDW-1:0]          ram_waddr, ram_raddr;
    logic                    out_free, emit;
    rsp_beat_t               beat;

    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign cnt_idx    = cnt_reg[IDW-1:0];
    assign cnt_id_ext = {{ID_W{1'b0}}, cnt_idx};
    assign cnt_id     = cnt_id_ext[ID_W-1:0];
    assign ev_id_ext  = {{ID_W{1'b0}}, ev_idx_reg};
    assign ev_id      = ev_id_ext[ID_W-1:0];
    assign scan_end   = (cnt_reg == LAST_CNT);
    assign slot_free  = !used_reg[cnt_idx];

    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            tid_hot[i] = ({{(32-ID_W){1'b0}}, tid_reg} == 32'(i));
        end
    end

    assign del_hit = |(used_reg & tid_hot);

    assign rd_ivl  = ram_rdata[SW-1:TIME_W];
    assign rd_dl   = ram_rdata[TIME_W-1:0];
    assign diff    = now_reg - rd_dl;
    assign due     = (diff != '0) && !diff[TIME_W-1];
    assign ev_fire = ev_valid_reg && used_reg[ev_idx_reg] && due;
    assign ev_rep  = ev_fire && (rep_cnt_reg < REP_MAX);
    assign tick_stall = ev_rep && pend_valid_reg && !out_free;

    assign ivl_sel   = (state_reg == S_TICK) ? rd_ivl : ivl_reg;
    assign new_dl    = now_reg + {1'b0, ivl_sel};
    assign ram_wdata = {ivl_sel, new_dl};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.operation)
                        OP_CREATE: state_next = S_CREATE;
                        OP_TICK:   state_next = S_TICK;
                        default:   state_next = S_SINGLE;
                    endcase
                end
            end
            S_CREATE:
            begin
                if ((scan_end || slot_free) && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (scan_end && !tick_stall)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH, S_SINGLE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        now_next        = now_reg;
        used_next       = used_reg;
        per_next        = per_reg;
        op_next         = op_reg;
        ivl_next        = ivl_reg;
        rep_mode_next   = rep_mode_reg;
        tid_next        = tid_reg;
        cnt_next        = cnt_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        rep_cnt_next    = rep_cnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_idx;
        ram_re          = 1'b0;
        ram_raddr       = cnt_idx;
        emit            = 1'b0;
        beat            = '{status: ST_FAILED, id: '0, last: 1'b1};
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    op_next         = cmd.operation;
                    ivl_next        = cmd.interval;
                    rep_mode_next   = cmd.repeat_mode;
                    tid_next        = cmd.timer_id;
                    cnt_next        = '0;
                    ev_valid_next   = 1'b0;
                    pend_valid_next = 1'b0;
                    rep_cnt_next    = '0;
                    if (cmd.operation == OP_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                end
            end
            S_CREATE:
            begin
                if (scan_end)
                begin
                    emit = out_free;
                end
                else if (slot_free)
                begin
                    if (out_free)
                    begin
                        emit               = 1'b1;
                        beat               = '{status: ST_CREATED, id: cnt_id, last: 1'b1};
                        ram_we             = 1'b1;
                        used_next[cnt_idx] = 1'b1;
                        per_next[cnt_idx]  = rep_mode_reg;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_TICK:
            begin
                if (!tick_stall)
                begin
                    if (ev_fire)
                    begin
                        if (per_reg[ev_idx_reg])
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = ev_idx_reg;
                        end
                        else
                        begin
                            used_next[ev_idx_reg] = 1'b0;
                        end
                    end
                    if (ev_rep)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit = 1'b1;
                            beat = '{status: ST_FIRED, id: pend_id_reg, last: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = ev_id;
                        rep_cnt_next    = rep_cnt_reg + 1'b1;
                    end
                    if (!scan_end)
                    begin
                        ram_re        = 1'b1;
                        cnt_next      = cnt_reg + 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = cnt_idx;
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        beat = '{status: ST_FIRED, id: pend_id_reg, last: 1'b1};
                    end
                    else
                    begin
                        beat = '{status: ST_NONE, id: '0, last: 1'b1};
                    end
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (op_reg == OP_DELETE)
                    begin
                        if (del_hit)
                        begin
                            used_next = used_reg & ~tid_hot;
                            beat      = '{status: ST_DELETED, id: tid_reg, last: 1'b1};
                        end
                        else
                        begin
                            beat = '{status: ST_FAILED, id: tid_reg, last: 1'b1};
                        end
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            used_reg       <= '0;
            per_reg        <= '0;
            cnt_reg        <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            rep_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            used_reg       <= used_next;
            per_reg        <= per_next;
            cnt_reg        <= cnt_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            rep_cnt_reg    <= rep_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ivl_reg      <= ivl_next;
        rep_mode_reg <= rep_mode_next;
        tid_reg      <= tid_next;
        ev_idx_reg   <= ev_idx_next;
        pend_id_reg  <= pend_id_next;
    end

    tbs_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tbs_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (emit),
        .beat  (beat),
        .free  (out_free),
        .rsp   (rsp)
    );

    a_now_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.operation == OP_TICK)
        |=> (now_reg == $past(now_reg) + 32'd1))
        else $error("time counter did not advance on tick");

    a_ram_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CREATE || state_reg == S_TICK))
        else $error("slot RAM written outside create or tick");

    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_TICK || state_reg == S_FINISH))
        else $error("pending fired beat outside tick");

    a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rep_cnt_reg <= REP_MAX)
        else $error("fired beat count beyond limit");

endmodule
`default_nettype wire

FILE: design/tbs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: design/tbs_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbs_out_stage
// Response register: holds one beat until the sink takes it.
// ----------------------------------------------------------------------------
module tbs_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  tbs_pkg::rsp_beat_t beat,
    output logic               free,
    tbs_rsp_if.source          rsp
);
    import tbs_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    rsp_beat_t beat_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat;
        end
    end

    assign rsp.valid     = valid_reg;
    assign rsp.status    = beat_reg.status;
    assign rsp.result_id = beat_reg.id;
    assign rsp.last      = beat_reg.last;

endmodule
`default_nettype wire
